// ===== src/sals_pkg.sv =====
// Shared types and constants for the shifting array list store.
package sals_pkg;

    localparam int POS_W       = 7;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int CMD_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_DISPLAY,
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_UPDATE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic                     pos_zero;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DISP,
        BK_SRCH
    } back_state_t;

endpackage

// ===== src/sals_front.sv =====
// Front end: takes input transfers and decodes them into queue commands.
module sals_front import sals_pkg::*; (
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     q_full,
    output logic                     q_push,
    output cmd_t                     q_item
);

    op_t op;

    always_comb begin
        case (s_command)
            CMD_DISPLAY: op = OP_DISPLAY;
            CMD_INSERT:  op = OP_INSERT;
            CMD_DELETE:  op = OP_DELETE;
            CMD_SEARCH:  op = OP_SEARCH;
            CMD_UPDATE:  op = OP_UPDATE;
            default:     op = OP_NOP;
        endcase
    end

    assign s_ready         = !q_full;
    assign q_push          = s_valid && !q_full;
    assign q_item.op       = op;
    assign q_item.pos_zero = (s_position == '0);
    assign q_item.pos      = s_position;
    assign q_item.value    = s_value;

endmodule

// ===== src/sals_queue.sv =====
// Small register queue of decoded commands between front and back.
module sals_queue import sals_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t item_in,
    output logic full,
    input  logic pop,
    output cmd_t item_out,
    output logic empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     fill_reg, fill_next;
    logic            push_ok, pop_ok;

    assign full     = (fill_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;
    assign item_out = slot_reg[rd_ptr_reg];

    // pointers wrap naturally, depth is a power of two
    always_comb begin
        wr_ptr_next = push_ok ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== src/sals_back.sv =====
// Back end: entry cells, command sequencer and result register.
module sals_back import sals_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    input  cmd_t                     q_item,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [POS_W-1:0]         m_found_position,
    output logic signed [DATA_W-1:0] m_element,
    output logic [CNT_W-1:0]         m_entry_count,
    output logic                     m_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] cell_reg  [DEPTH];
    logic signed [DATA_W-1:0] cell_next [DEPTH];

    back_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hitpos_reg, hitpos_next;
    logic          hit_reg, hit_next;
    logic signed [DATA_W-1:0] key_reg, key_next;

    logic                     m_valid_reg;
    status_t                  m_status_reg;
    logic [POS_W-1:0]         m_pos_reg;
    logic signed [DATA_W-1:0] m_elem_reg;
    logic [CNT_W-1:0]         m_cnt_reg;
    logic                     m_last_reg;

    logic                     out_free, out_load;
    status_t                  o_status;
    logic [POS_W-1:0]         o_pos;
    logic signed [DATA_W-1:0] o_elem;
    logic                     o_last;

    logic do_ins, do_del, do_upd, do_rot;
    logic [POS_W-1:0] count7, count_p1, pm1;
    logic scan_fin, key_match;

    assign out_free  = !m_valid_reg || m_ready;
    assign count7    = POS_W'(count_reg);
    assign count_p1  = count7 + POS_W'(1);
    assign pm1       = q_item.pos - POS_W'(1);
    assign scan_fin  = (idx_reg == count_reg - CW'(1));
    assign key_match = (cell_reg[0] == key_reg);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        hitpos_next = hitpos_reg;
        key_next    = key_reg;
        q_pop       = 1'b0;
        out_load    = 1'b0;
        o_status    = ST_OK;
        o_pos       = '0;
        o_elem      = '0;
        o_last      = 1'b1;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_upd      = 1'b0;
        do_rot      = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        OP_DISPLAY: begin
                            if (count_reg == '0) begin
                                out_load = 1'b1;
                                o_status = ST_EMPTY;
                            end else begin
                                state_next = BK_DISP;
                                idx_next   = '0;
                            end
                        end
                        OP_INSERT: begin
                            out_load = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                o_status = ST_FULL;
                            end else if (q_item.pos_zero || q_item.pos > count_p1) begin
                                o_status = ST_BADPOS;
                            end else begin
                                do_ins     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            out_load = 1'b1;
                            if (count_reg == '0) begin
                                o_status = ST_EMPTY;
                            end else if (q_item.pos_zero || q_item.pos > count7) begin
                                o_status = ST_BADPOS;
                            end else begin
                                do_del     = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_SEARCH: begin
                            if (count_reg == '0) begin
                                out_load = 1'b1;
                                o_status = ST_NOTFOUND;
                            end else begin
                                state_next = BK_SRCH;
                                idx_next   = '0;
                                hit_next   = 1'b0;
                                key_next   = q_item.value;
                            end
                        end
                        OP_UPDATE: begin
                            out_load = 1'b1;
                            if (q_item.pos_zero || q_item.pos > count7) begin
                                o_status = ST_BADPOS;
                            end else begin
                                do_upd = 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_DISP: begin
                // head cell is shown, then the live entries rotate by one
                if (out_free) begin
                    out_load = 1'b1;
                    o_pos    = POS_W'(idx_reg) + POS_W'(1);
                    o_elem   = cell_reg[0];
                    o_last   = scan_fin;
                    do_rot   = 1'b1;
                    idx_next = idx_reg + CW'(1);
                    if (scan_fin) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_SRCH: begin
                // full rotation restores the order; first hit is kept
                if (!scan_fin || out_free) begin
                    do_rot   = 1'b1;
                    idx_next = idx_reg + CW'(1);
                    if (key_match && !hit_reg) begin
                        hit_next    = 1'b1;
                        hitpos_next = idx_reg + CW'(1);
                    end
                    if (scan_fin) begin
                        out_load   = 1'b1;
                        state_next = BK_IDLE;
                        if (hit_reg) begin
                            o_pos = POS_W'(hitpos_reg);
                        end else if (key_match) begin
                            o_pos = POS_W'(idx_reg) + POS_W'(1);
                        end else begin
                            o_status = ST_NOTFOUND;
                        end
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] below_w;
        logic signed [DATA_W-1:0] above_w;
        logic [POS_W-1:0]         here_w;

        assign here_w = POS_W'(i);

        if (i > 0) begin : g_below
            assign below_w = cell_reg[i-1];
        end else begin : g_below0
            assign below_w = '0;
        end

        if (i < DEPTH - 1) begin : g_above
            assign above_w = cell_reg[i+1];
        end else begin : g_abovewrap
            assign above_w = cell_reg[0];
        end

        always_comb begin
            cell_next[i] = cell_reg[i];
            if (do_ins) begin
                if (here_w == pm1) begin
                    cell_next[i] = q_item.value;
                end else if (here_w > pm1 && here_w <= count7) begin
                    cell_next[i] = below_w;
                end
            end else if (do_del) begin
                if (here_w >= pm1 && here_w + POS_W'(1) < count7) begin
                    cell_next[i] = above_w;
                end
            end else if (do_upd) begin
                if (here_w == pm1) begin
                    cell_next[i] = q_item.value;
                end
            end else if (do_rot) begin
                if (here_w + POS_W'(1) == count7) begin
                    cell_next[i] = cell_reg[0];
                end else if (here_w < count7) begin
                    cell_next[i] = above_w;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        hitpos_reg <= hitpos_next;
        key_reg    <= key_next;
        if (out_load) begin
            m_status_reg <= o_status;
            m_pos_reg    <= o_pos;
            m_elem_reg   <= o_elem;
            m_cnt_reg    <= CNT_W'(count_next);
            m_last_reg   <= o_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_pos_reg;
    assign m_element        = m_elem_reg;
    assign m_entry_count    = m_cnt_reg;
    assign m_last           = m_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_IDLE) |-> !q_pop)
        else $error("queue popped during a scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !q_pop |=> $stable(count_reg))
        else $error("entry count changed outside a command start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_IDLE) |-> (idx_reg < count_reg))
        else $error("scan index ran past the entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DISP && out_load && o_last) |=> (state_reg == BK_IDLE))
        else $error("display did not end on its last transfer");
`endif

endmodule

// ===== src/shifting_array_list_store_top.sv =====
// Top level of the shifting array list store.
//
//   channel | ports                                            | role
//   --------+--------------------------------------------------+---------------
//   input   | s_valid s_ready s_command s_position s_value     | commands in
//   result  | m_valid m_ready m_status m_found_position        | results out
//           | m_element m_entry_count m_last                   |
//
// Insert, delete, update, error cases and unknown commands finish in the
// back end as the command is taken. Search and display on a non-empty list
// take the command, then step once per entry while the live cells rotate
// once; display gives one transfer per entry. A two-entry command queue sits
// between front and back, so the input side keeps accepting until it holds
// two commands while the back end scans or the result side stalls.
// Reset clears the entry count, queue and result valid; cell contents stay
// undefined until written by insert or update.
module shifting_array_list_store_top import sals_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [POS_W-1:0]         m_found_position,
    output logic signed [DATA_W-1:0] m_element,
    output logic [CNT_W-1:0]         m_entry_count,
    output logic                     m_last
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_in, q_out;

    sals_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_position (s_position),
        .s_value    (s_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    sals_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_out),
        .empty    (q_empty)
    );

    sals_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .q_item           (q_out),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_element        (m_element),
        .m_entry_count    (m_entry_count),
        .m_last           (m_last)
    );

endmodule
